// ===== rtl/core/sdds_pkg.sv =====
// Shared types and constants for the scrolling digit display scanner.
package sdds_pkg;

   localparam int CMD_W    = 2;
   localparam int INDEX_W  = 6;
   localparam int CODE_W   = 8;
   localparam int LENGTH_W = 7;
   localparam int DIGIT_W  = 2;
   localparam int BRIGHT_W = 4;
   localparam int POS_W    = 9;
   localparam int CALC_W   = 11;
   localparam int POS_MAX  = 255;

   localparam logic [CODE_W-1:0] BLANK_CODE = 8'd32;

   typedef enum logic [CMD_W-1:0] {
      CMD_SCAN   = 2'd0,
      CMD_SCROLL = 2'd1,
      CMD_WRITE  = 2'd2,
      CMD_SHOW   = 2'd3
   } cmd_type;

endpackage

// ===== rtl/core/sdds_req_if.sv =====
// Request channel interface: command beats into the scanner.
interface sdds_req_if;
   logic                             valid;
   logic                             ready;
   logic [sdds_pkg::CMD_W-1:0]       cmd;
   logic [sdds_pkg::INDEX_W-1:0]     char_index;
   logic [sdds_pkg::CODE_W-1:0]      char_code;
   logic                             moving;
   logic [sdds_pkg::LENGTH_W-1:0]    msg_length;

   modport source (output valid, cmd, char_index, char_code, moving, msg_length,
                   input ready);
   modport sink (input valid, cmd, char_index, char_code, moving, msg_length,
                 output ready);
endinterface

// ===== rtl/core/sdds_rsp_if.sv =====
// Response channel interface: digit and glyph beats out of the scanner.
interface sdds_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [sdds_pkg::DIGIT_W-1:0]  digit_index;
   logic [sdds_pkg::CODE_W-1:0]   glyph_code;

   modport source (output valid, digit_index, glyph_code, input ready);
   modport sink (input valid, digit_index, glyph_code, output ready);
endinterface

// ===== rtl/core/scrolling_digit_display_scanner_top.sv =====
// Scrolling digit display scanner: message store, dimming and digit scan.
//
// One request beat is taken per clock while req_chan.ready is high. Write
// beats fill a MSG_DEPTH-entry message store, show beats start a static or
// scrolling message, scroll beats move a scrolling window one position, and
// scan beats advance the dim counter. A scan beat that reaches BRIGHT_LEVELS
// steps to the next digit and yields its character or a blank; any other scan
// beat at or above the brightness setting yields a blank for the current
// digit. A response passes the state update and registered store read, then
// the response register. The response side holds two beats, so requests keep
// flowing while a response waits. The user must write brightness through
// csr_we/csr_wdata while idle; the block itself does not enforce this.
module scrolling_digit_display_scanner_top #(
   parameter int DIGITS        = 4,
   parameter int BRIGHT_LEVELS = 8,
   parameter int MSG_DEPTH     = 64
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic [sdds_pkg::BRIGHT_W-1:0]   csr_wdata,
   sdds_req_if.sink                        req_chan,
   sdds_rsp_if.source                      rsp_chan
);

   localparam int AW = $clog2(MSG_DEPTH);
   localparam int DW = $clog2(DIGITS + 1);
   localparam int CW = sdds_pkg::CALC_W;
   localparam int PW = sdds_pkg::POS_W;

   localparam logic signed [CW-1:0] DIG_S   = CW'(DIGITS);
   localparam logic signed [CW-1:0] DEPTH_S = CW'(MSG_DEPTH);
   localparam logic signed [CW-1:0] PMAX_S  = CW'(sdds_pkg::POS_MAX);

   logic [sdds_pkg::CODE_W-1:0] store [MSG_DEPTH];

   logic [sdds_pkg::BRIGHT_W-1:0] bright_ff;
   logic [sdds_pkg::BRIGHT_W-1:0] dim_ff, dim_in;
   logic signed [PW-1:0]          pos_ff, pos_in;
   logic signed [PW-1:0]          end_ff, end_in;
   logic [DW-1:0]                 dig_ff, dig_in;
   logic [AW-1:0]                 wb_ff, wb_in;
   logic                          scroll_ff, scroll_in;

   logic                          p_valid_ff, p_valid_in;
   logic [sdds_pkg::DIGIT_W-1:0]  p_digit_ff, p_digit_in;
   logic                          p_blank_ff, p_blank_in;
   logic [sdds_pkg::CODE_W-1:0]   mem_q_ff;

   logic                          out_valid_ff, out_valid_in;
   logic [sdds_pkg::DIGIT_W-1:0]  out_digit_ff, out_digit_in;
   logic [sdds_pkg::CODE_W-1:0]   out_glyph_ff, out_glyph_in;

   logic                          accept;
   logic                          p_move;
   logic                          rd_en;
   logic [AW-1:0]                 rd_addr;
   logic                          wr_en;
   logic [AW-1:0]                 wr_addr;
   sdds_pkg::cmd_type             cmd;

   assign cmd            = sdds_pkg::cmd_type'(req_chan.cmd);
   assign req_chan.ready = !p_valid_ff || !out_valid_ff || rsp_chan.ready;
   assign accept         = req_chan.valid && req_chan.ready;
   assign p_move         = p_valid_ff && (!out_valid_ff || rsp_chan.ready);

   assign rsp_chan.valid       = out_valid_ff;
   assign rsp_chan.digit_index = out_digit_ff;
   assign rsp_chan.glyph_code  = out_glyph_ff;

   assign wr_en   = accept && (cmd == sdds_pkg::CMD_WRITE)
                    && (PW'(req_chan.char_index) < PW'(MSG_DEPTH));
   assign wr_addr = AW'(PW'(req_chan.char_index));

   always_comb begin
      logic [sdds_pkg::BRIGHT_W-1:0] dim_next;
      logic signed [CW-1:0]          pos_w;
      logic signed [CW-1:0]          end_w;
      logic signed [CW-1:0]          idx_w;
      logic signed [CW-1:0]          len_w;
      logic [DW-1:0]                 dig_w;

      dim_in     = dim_ff;
      pos_in     = pos_ff;
      end_in     = end_ff;
      dig_in     = dig_ff;
      wb_in      = wb_ff;
      scroll_in  = scroll_ff;
      p_digit_in = p_digit_ff;
      p_blank_in = p_blank_ff;
      rd_en      = 1'b0;
      rd_addr    = '0;

      dim_next = dim_ff + 1'b1;
      pos_w    = CW'(pos_ff);
      end_w    = CW'(end_ff);
      dig_w    = dig_ff + 1'b1;
      idx_w    = '0;
      len_w    = signed'(CW'(req_chan.msg_length));

      if (accept) begin
         case (cmd)
            sdds_pkg::CMD_SCAN: begin
               if (dim_next == sdds_pkg::BRIGHT_W'(BRIGHT_LEVELS)) begin
                  dim_in = '0;
                  if (pos_w < PMAX_S) begin
                     pos_w = pos_w + 1'b1;
                  end
                  if (dig_w == DW'(DIGITS)) begin
                     pos_w = pos_w - DIG_S;
                     dig_w = '0;
                  end
                  idx_w      = signed'(CW'(wb_ff)) + pos_w;
                  p_blank_in = 1'b1;
                  if (pos_w < 0) begin
                     p_blank_in = 1'b1;
                  end else if (pos_w > end_w) begin
                     if (pos_w == end_w + DIG_S) begin
                        pos_w = '0;
                        dig_w = DW'(DIGITS - 1);
                     end
                  end else if (idx_w < end_w && idx_w < DEPTH_S) begin
                     p_blank_in = 1'b0;
                     rd_en      = 1'b1;
                     rd_addr    = idx_w[AW-1:0];
                  end
                  pos_in     = pos_w[PW-1:0];
                  dig_in     = dig_w;
                  p_digit_in = dig_w[sdds_pkg::DIGIT_W-1:0];
               end else begin
                  dim_in     = dim_next;
                  p_blank_in = 1'b1;
                  p_digit_in = dig_ff[sdds_pkg::DIGIT_W-1:0];
               end
            end
            sdds_pkg::CMD_SCROLL: begin
               if (scroll_ff && pos_w < PMAX_S) begin
                  pos_in = PW'(pos_w + 1'b1);
               end
            end
            sdds_pkg::CMD_WRITE: begin
               dim_in = dim_ff;
            end
            sdds_pkg::CMD_SHOW: begin
               if (len_w > DEPTH_S) begin
                  len_w = DEPTH_S;
               end
               end_in = len_w[PW-1:0];
               pos_in = '0;
               if (!req_chan.moving) begin
                  scroll_in = 1'b0;
                  dig_in    = '0;
                  wb_in     = (len_w > DIG_S) ? AW'(len_w - DIG_S) : '0;
               end else begin
                  scroll_in = 1'b1;
                  dig_in    = DW'(DIGITS - 1);
                  wb_in     = '0;
               end
            end
            default: begin
               dim_in = dim_ff;
            end
         endcase
      end
   end

   always_comb begin
      logic p_load;

      p_load     = accept && (cmd == sdds_pkg::CMD_SCAN)
                   && ((dim_ff + 1'b1) == sdds_pkg::BRIGHT_W'(BRIGHT_LEVELS)
                       || (dim_ff + 1'b1) >= bright_ff);
      p_valid_in = p_load || (p_valid_ff && !p_move);

      out_valid_in = p_move || (out_valid_ff && !rsp_chan.ready);
      out_digit_in = out_digit_ff;
      out_glyph_in = out_glyph_ff;
      if (p_move) begin
         out_digit_in = p_digit_ff;
         out_glyph_in = p_blank_ff ? sdds_pkg::BLANK_CODE : mem_q_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store[wr_addr] <= req_chan.char_code;
      end
      if (rd_en) begin
         mem_q_ff <= store[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bright_ff    <= sdds_pkg::BRIGHT_W'(8);
         dim_ff       <= '0;
         pos_ff       <= '0;
         end_ff       <= '1;
         dig_ff       <= '0;
         wb_ff        <= '0;
         scroll_ff    <= 1'b0;
         p_valid_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            bright_ff <= csr_wdata;
         end
         dim_ff       <= dim_in;
         pos_ff       <= pos_in;
         end_ff       <= end_in;
         dig_ff       <= dig_in;
         wb_ff        <= wb_in;
         scroll_ff    <= scroll_in;
         p_valid_ff   <= p_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         p_digit_ff <= p_digit_in;
         p_blank_ff <= p_blank_in;
      end
      out_digit_ff <= out_digit_in;
      out_glyph_ff <= out_glyph_in;
   end

endmodule
